// ===== src/cid_pkg.sv =====
// ----------------------------------------------------------------------------
// cid_pkg: shared types and constants of the compact index decoder
// Byte item layout, status codes and the value-bit placement of later bytes.
// ----------------------------------------------------------------------------
package cid_pkg;

   // Later bytes allowed after the first byte of an index
   localparam int unsigned MaxExtraBytes = 4;

   localparam int unsigned ValueWidth  = 32;
   localparam int unsigned StatusWidth = 2;
   localparam int unsigned LengthWidth = 3;

   // Result status codes
   typedef enum logic [StatusWidth-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_TOO_LONG  = 2'd1,
      STATUS_TRUNCATED = 2'd2
   } status_type;

   // One input item held in the input register
   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_data;
   } byte_item_type;

   // One result item
   typedef struct packed {
      logic [LengthWidth-1:0] byte_length;
      status_type             status;
      logic [ValueWidth-1:0]  index_value;
   } result_type;

   // Place the seven value bits of the later byte at position 6 + 7 * k,
   // where count is the number of bytes taken before this one (k = count - 1).
   // Bits above 31 drop.
   function automatic logic [ValueWidth-1:0] later_bits(
      input logic [LengthWidth-1:0] count,
      input logic [6:0]             bits
   );
      logic [ValueWidth-1:0] placed;
      placed = '0;
      case (count)
         3'd1:    placed = {19'd0, bits, 6'd0};
         3'd2:    placed = {12'd0, bits, 13'd0};
         3'd3:    placed = {5'd0, bits, 20'd0};
         3'd4:    placed = {bits[4:0], 27'd0};
         default: placed = '0;
      endcase
      return placed;
   endfunction

endpackage

// ===== src/cid_in_stage.sv =====
// ----------------------------------------------------------------------------
// cid_in_stage: input register of the compact index decoder
// Holds one byte item and its valid flag; refills in the cycle it is drained.
// ----------------------------------------------------------------------------
module cid_in_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  cid_pkg::byte_item_type req_item,
   input  logic                   take,
   output logic                   item_valid,
   output cid_pkg::byte_item_type item
);

   logic                   valid_ff;
   logic                   valid_in;
   cid_pkg::byte_item_type item_ff;

   // Accept while empty or while the held item leaves this cycle
   assign req_tready = !valid_ff || take;
   assign valid_in   = req_tvalid ? 1'b1 : (valid_ff && !take);

   // Hold valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            valid_ff <= valid_in;
         end
      end
   end

   // Load payload on accept
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== src/cid_decode.sv =====
// ----------------------------------------------------------------------------
// cid_decode: index state and result register of the compact index decoder
// Folds one byte a cycle into the count, sign and magnitude (a stalled result register holds
// up index-ending bytes) and loads the result register when an index completes, runs too long or is cut short.
// ----------------------------------------------------------------------------
module cid_decode #(
   parameter int unsigned MaxExtraBytes = cid_pkg::MaxExtraBytes
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_valid,
   input  cid_pkg::byte_item_type item,
   output logic                   take,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output cid_pkg::result_type    rsp_result
);

   logic [cid_pkg::LengthWidth-1:0] count_ff;
   logic [cid_pkg::LengthWidth-1:0] count_in;
   logic                            sign_ff;
   logic                            sign_in;
   logic [cid_pkg::ValueWidth-1:0]  mag_ff;
   logic [cid_pkg::ValueWidth-1:0]  mag_in;
   logic                            more;
   logic                            too_long;
   logic                            emit;
   logic                            out_valid_ff;
   cid_pkg::result_type             result_ff;
   cid_pkg::result_type             result_in;

   // Fold the byte into the running index
   always_comb begin
      if (count_ff == '0) begin
         sign_in = item.data_byte[7];
         mag_in  = {26'd0, item.data_byte[5:0]};
         more    = item.data_byte[6];
      end else begin
         sign_in = sign_ff;
         mag_in  = mag_ff | cid_pkg::later_bits(count_ff, item.data_byte[6:0]);
         more    = item.data_byte[7];
      end
      count_in = count_ff + 3'd1;
   end

   // Decide whether this byte ends the index
   assign too_long = more && (count_in > cid_pkg::LengthWidth'(MaxExtraBytes));
   assign emit     = !more || too_long || item.end_of_data;
   assign take     = item_valid && (!emit || !out_valid_ff || rsp_tready);

   // Build the result item
   always_comb begin
      result_in.byte_length = count_in;
      if (!more) begin
         result_in.status      = cid_pkg::STATUS_OK;
         result_in.index_value = sign_in ? (~mag_in + 32'd1) : mag_in;
      end else if (too_long) begin
         result_in.status      = cid_pkg::STATUS_TOO_LONG;
         result_in.index_value = '0;
      end else begin
         result_in.status      = cid_pkg::STATUS_TRUNCATED;
         result_in.index_value = '0;
      end
   end

   // Advance index state; drop to idle once a result is issued
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sign_ff  <= 1'b0;
         mag_ff   <= '0;
      end else begin
         if (take) begin
            if (emit) begin
               count_ff <= '0;
               sign_ff  <= 1'b0;
               mag_ff   <= '0;
            end else begin
               count_ff <= count_in;
               sign_ff  <= sign_in;
               mag_ff   <= mag_in;
            end
         end
      end
   end

   // Hold result valid until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         if (take && emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Load result payload
   always_ff @(posedge clock) begin
      if (take && emit) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_result = result_ff;

endmodule

// ===== src/compact_index_decoder.sv =====
// ----------------------------------------------------------------------------
// compact_index_decoder: signed variable-length compact index decoder
// Byte stream in, one decoded index or error status out per index.
// ----------------------------------------------------------------------------
// Takes one byte per cycle and issues one result per index: the value with
// status ok, status too long when the last allowed later byte (MaxExtraBytes,
// four by default) still continues, or status truncated when a byte marked
// with tlast still continues. Each byte passes an input register, the
// shift-and-OR logic and the result register, so a byte can be accepted
// every cycle; a stalled result register holds back only bytes that would
// end another index.
// ----------------------------------------------------------------------------
module compact_index_decoder #(
   parameter int unsigned MaxExtraBytes = cid_pkg::MaxExtraBytes
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // end_of_data
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [31:0] index_value, [33:32] status,
                                    // [36:34] byte_length, [39:37] zero
);

   cid_pkg::byte_item_type req_item;
   cid_pkg::byte_item_type item;
   cid_pkg::result_type    result;
   logic                   item_valid;
   logic                   take;

   assign req_item.data_byte   = req_tdata;
   assign req_item.end_of_data = req_tlast;

   cid_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   cid_decode #(
      .MaxExtraBytes (MaxExtraBytes)
   ) u_decode (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .take       (take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_result (result)
   );

   // Pack result fields from the lowest bit up
   assign rsp_tdata = {3'd0, result.byte_length, result.status, result.index_value};

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the compact index decoder
// Drives byte items with random gaps and tlast marks, predicts each decoded
// index or error status, and compares every result item field by field.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DrainCycles = 6;
   localparam int MaxReported = 40;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] data_byte
   logic        req_tlast;   // end_of_data
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // [31:0] index_value, [33:32] status,
                             // [36:34] byte_length, [39:37] zero

   // Predicted decoder state
   logic [cid_pkg::LengthWidth-1:0] idx_count;
   logic                            idx_negative;
   logic [cid_pkg::ValueWidth-1:0]  idx_magnitude;

   cid_pkg::result_type expected_results[$];

   int source_idle_pct;
   int sink_idle_pct;
   int sink_stall_cycles;
   int bytes_sent;
   int mismatches;
   int n_ok;
   int n_too_long;
   int n_truncated;

   compact_index_decoder u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 12 ns clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Give up after a generous fixed time
   initial begin
      #2_500_000;
      $display("CHECKS FAILED");
      $finish;
   end

   // Count every mismatch, print only the first few
   task automatic log_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MaxReported) begin
         $display("[%0t] mismatch: %s", $time, msg);
      end
   endtask

   // Advance the predicted decoder by one accepted byte
   task automatic decode_byte(input logic [7:0] data, input logic last);
      logic                more;
      int                  shift;
      cid_pkg::result_type res;
      if (idx_count == 0) begin
         idx_negative  = data[7];
         idx_magnitude = {26'd0, data[5:0]};
         more          = data[6];
      end else begin
         shift = 6 + 7 * (idx_count - 1);
         if (shift < cid_pkg::ValueWidth) begin
            idx_magnitude |= {25'd0, data[6:0]} << shift;
         end
         more = data[7];
      end
      idx_count = idx_count + 3'd1;
      if (!more || (idx_count - 1 >= cid_pkg::MaxExtraBytes) || last) begin
         res.byte_length = idx_count;
         res.index_value = '0;
         if (!more) begin
            res.status      = cid_pkg::STATUS_OK;
            res.index_value = idx_negative ? 32'd0 - idx_magnitude : idx_magnitude;
         end else if (idx_count - 1 >= cid_pkg::MaxExtraBytes) begin
            // too long wins over end of data
            res.status = cid_pkg::STATUS_TOO_LONG;
         end else begin
            res.status = cid_pkg::STATUS_TRUNCATED;
         end
         expected_results.push_back(res);
         idx_count     = '0;
         idx_negative  = 1'b0;
         idx_magnitude = '0;
      end
   endtask

   // Offer one item, hold it until accepted, then predict
   task automatic push_byte(input logic [7:0] data, input logic last);
      while ($urandom_range(99) < source_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
      decode_byte(data, last);
   endtask

   // Drop valid and wait for every expected result, plus pipeline slack
   task automatic pause_until_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // Payload bits biased toward all zeros and all ones
   function automatic logic [6:0] value_bits();
      int pick;
      pick = $urandom_range(9);
      if (pick == 0) return 7'h00;
      if (pick == 1) return 7'h7F;
      return 7'($urandom);
   endfunction

   // Send one index: mostly well formed, some too long, some cut short
   task automatic send_random_index();
      int         mode;
      int         n_bytes;
      int         cut;
      logic       more;
      logic       last;
      logic [6:0] bits;
      mode    = $urandom_range(99);
      n_bytes = $urandom_range(1, cid_pkg::MaxExtraBytes + 1);
      cut     = -1;
      if (mode < 12) begin
         n_bytes = cid_pkg::MaxExtraBytes + 1;
      end else if (mode < 25) begin
         n_bytes = $urandom_range(2, cid_pkg::MaxExtraBytes + 1);
         cut     = $urandom_range(0, n_bytes - 2);
      end
      for (int i = 0; i < n_bytes; i++) begin
         bits = value_bits();
         more = (mode < 12) || (i < n_bytes - 1);
         last = (i == cut) || ((i == n_bytes - 1) && ($urandom_range(7) == 0));
         if (i == 0) begin
            push_byte({bits[6], more, bits[5:0]}, last);
         end else begin
            push_byte({more, bits}, last);
         end
         if (i == cut) break;
      end
   endtask

   // Corner cases: field extremes, sign handling, every status
   task automatic test_directed_cases();
      logic [8:0] corner_bytes [23] = '{
         // single-byte: zero, max positive, negative zero, max negative
         9'h000, 9'h03F, 9'h080, 9'h0BF,
         // five bytes ending cleanly, top bits of the last byte drop
         9'h07F, 9'h0FF, 9'h0FF, 9'h0FF, 9'h07F,
         // minimum value: sign with magnitude 0x80000000
         9'h0C0, 9'h080, 9'h080, 9'h080, 9'h010,
         // too long, also marked end of data
         9'h040, 9'h080, 9'h080, 9'h080, 9'h180,
         // truncated on a later byte, then on a first byte
         9'h041, 9'h185, 9'h1C1,
         // complete on the last byte
         9'h105
      };
      source_idle_pct = 0;
      sink_idle_pct   = 0;
      foreach (corner_bytes[i]) push_byte(corner_bytes[i][7:0], corner_bytes[i][8]);
      pause_until_drained();
   endtask

   // Random stream with the given idling on each side
   task automatic test_random_stream(input int src_pct, input int snk_pct,
                                     input int n_bytes);
      int target;
      int burst;
      source_idle_pct = src_pct;
      sink_idle_pct   = snk_pct;
      target          = bytes_sent + n_bytes;
      while (bytes_sent < target) begin
         if ($urandom_range(99) < 15) begin
            // raw noise, closed by an end-of-data mark to realign
            burst = $urandom_range(1, 8);
            for (int i = 0; i < burst; i++) begin
               push_byte(8'($urandom), (i == burst - 1) || ($urandom_range(7) == 0));
            end
         end else begin
            send_random_index();
         end
      end
      pause_until_drained();
   endtask

   // Long receiver hold-off while the sender keeps offering items
   task automatic test_output_backpressure();
      source_idle_pct   = 0;
      sink_idle_pct     = 0;
      sink_stall_cycles = 300;
      repeat (40) send_random_index();
      pause_until_drained();
   endtask

   // Receiver: random stalls, plus a counted hold-off on request
   initial begin : sink_model
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (sink_stall_cycles > 0) begin
            rsp_tready <= 1'b0;
            sink_stall_cycles--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= sink_idle_pct);
         end
      end
   end

   // Compare each accepted result with the oldest prediction
   always @(posedge clock) begin : check_results
      cid_pkg::result_type got;
      cid_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = cid_pkg::result_type'(rsp_tdata[36:0]);
         if (expected_results.size() == 0) begin
            log_mismatch($sformatf("unexpected result %h", rsp_tdata));
         end else begin
            want = expected_results.pop_front();
            if (got.index_value !== want.index_value) begin
               log_mismatch($sformatf("index_value %0d, expected %0d",
                  $signed(got.index_value), $signed(want.index_value)));
            end
            if (got.status !== want.status) begin
               log_mismatch($sformatf("status %0d, expected %0d",
                  got.status, want.status));
            end
            if (got.byte_length !== want.byte_length) begin
               log_mismatch($sformatf("byte_length %0d, expected %0d",
                  got.byte_length, want.byte_length));
            end
            if (rsp_tdata[39:37] !== 3'b000) begin
               log_mismatch($sformatf("pad bits %b, expected zero", rsp_tdata[39:37]));
            end
            case (want.status)
               cid_pkg::STATUS_OK:       n_ok++;
               cid_pkg::STATUS_TOO_LONG: n_too_long++;
               default:                  n_truncated++;
            endcase
         end
      end
   end

   // Reset, run the tests in turn, report
   initial begin
      idx_count         = '0;
      idx_negative      = 1'b0;
      idx_magnitude     = '0;
      source_idle_pct   = 0;
      sink_idle_pct     = 0;
      sink_stall_cycles = 0;
      bytes_sent        = 0;
      mismatches        = 0;
      n_ok              = 0;
      n_too_long        = 0;
      n_truncated       = 0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_random_stream(26, 69, 300);
      test_output_backpressure();
      test_random_stream(69, 26, 300);
      test_random_stream(0, 0, 300);

      if (expected_results.size() != 0) begin
         log_mismatch($sformatf("%0d results never arrived", expected_results.size()));
      end
      $display("Sent %0d bytes: %0d indices decoded, %0d too long, %0d truncated",
         bytes_sent, n_ok, n_too_long, n_truncated);
      $display("Covered both-side idling, a 300-cycle output hold-off and drain pauses");
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
